// ===== rtl/tcal_pkg.sv =====
package tcal_pkg;

    // field widths
    localparam int TYPE_W    = 5;
    localparam int CODE_W    = 6;
    localparam int RAW_W     = 12;
    localparam int PRES_W    = RAW_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 12;
    localparam int SX_W      = 9;
    localparam int SY_W      = 8;
    localparam int PHASE_W   = 2;
    localparam int OUT_W     = 16;

    // arithmetic widths
    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = 40;
    localparam int CLO_W     = 20;
    localparam int CHI_W     = COEF_W - CLO_W;
    localparam int MA_W      = 25;
    localparam int MB_W      = 13;
    localparam int P_W       = MA_W + MB_W;
    localparam int ACC_W     = 56;
    localparam int NUM_W     = 37;
    localparam int DET_W     = 28;
    localparam int DIV_W     = NUM_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_W);
    localparam int UOP_W     = 5;

    localparam logic [TYPE_W-1:0] ABS_TYPE = 5'd3;
    localparam logic [CODE_W-1:0] CODE_X   = 6'd0;
    localparam logic [CODE_W-1:0] CODE_Y   = 6'd1;
    localparam logic [CODE_W-1:0] CODE_P   = 6'd24;

    localparam logic [PHASE_W-1:0] PHASE_RUN = 2'd3;
    localparam logic [PHASE_W-1:0] PHASE_P2  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESH = 3'd0,
        CFG_RX0    = 3'd1,
        CFG_RX1    = 3'd2,
        CFG_RX2    = 3'd3,
        CFG_RY0    = 3'd4,
        CFG_RY1    = 3'd5,
        CFG_RY2    = 3'd6
    } cfg_reg_t;

    // multiplier operand sources
    typedef enum logic [3:0] {
        A_DX0, A_DX1, A_DS0, A_DS1, A_X0, A_X1, A_X2, A_TMP, A_CLO, A_CHI
    } a_sel_t;

    typedef enum logic [3:0] {
        B_DY0, B_DY1, B_DS1, B_DX1, B_Y0, B_Y1, B_Y2, B_S0, B_S1, B_S2,
        B_RX, B_RY, B_ONE
    } b_sel_t;

    typedef struct packed {
        a_sel_t      a_sel;
        b_sel_t      b_sel;
        logic        tmp;    // product goes to the temp register
        logic        clr;    // accumulator starts from zero
        logic        neg;    // subtract the product
        logic        sh20;   // product weighted by 2^20
        logic [1:0]  cofs;   // coefficient offset within an axis
    } uop_t;

    // micro program layout
    localparam logic [UOP_W-1:0] UOP_DET_FIRST  = 5'd0;
    localparam logic [UOP_W-1:0] UOP_DET_LAST   = 5'd1;
    localparam logic [UOP_W-1:0] UOP_NUM0_FIRST = 5'd2;
    localparam logic [UOP_W-1:0] UOP_NUM0_LAST  = 5'd3;
    localparam logic [UOP_W-1:0] UOP_NUM1_FIRST = 5'd4;
    localparam logic [UOP_W-1:0] UOP_NUM1_LAST  = 5'd5;
    localparam logic [UOP_W-1:0] UOP_NUM2_FIRST = 5'd6;
    localparam logic [UOP_W-1:0] UOP_NUM2_LAST  = 5'd17;
    localparam logic [UOP_W-1:0] UOP_RUN_FIRST  = 5'd18;
    localparam logic [UOP_W-1:0] UOP_RUN_LAST   = 5'd23;

    typedef struct packed {
        logic               take;
        logic               cap;
        logic [1:0]         pt_idx;
        uop_t               uop;
        logic               axis;
        logic               mul;
        logic               acc;
        logic               det_load;
        logic               div_init;
        logic               div_step;
        logic               coef_wr;
        logic [2:0]         coef_idx;
        logic               fin;
        logic               out_load;
        logic [PHASE_W-1:0] res_phase;
        logic               res_cap;
        logic               res_err;
        logic               res_run;
    } cmd_t;

    typedef struct packed {
        logic capture;
        logic det_zero;
    } st_t;

    function automatic uop_t mk(input a_sel_t a, input b_sel_t b, input logic tmp,
                                input logic clr, input logic neg, input logic sh,
                                input logic [1:0] cofs);
        uop_t u;
        u.a_sel = a;
        u.b_sel = b;
        u.tmp   = tmp;
        u.clr   = clr;
        u.neg   = neg;
        u.sh20  = sh;
        u.cofs  = cofs;
        return u;
    endfunction

    function automatic uop_t uop_rom(input logic [UOP_W-1:0] idx);
        uop_t u;
        case (idx)
            // determinant
            5'd0:    u = mk(A_DX0, B_DY1, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0);
            5'd1:    u = mk(A_DX1, B_DY0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0);
            // first numerator
            5'd2:    u = mk(A_DS0, B_DY1, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0);
            5'd3:    u = mk(A_DS1, B_DY0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0);
            // second numerator
            5'd4:    u = mk(A_DX0, B_DS1, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0);
            5'd5:    u = mk(A_DS0, B_DX1, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0);
            // offset numerator as six triple products
            5'd6:    u = mk(A_X2, B_Y0, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0);
            5'd7:    u = mk(A_TMP, B_S1, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0);
            5'd8:    u = mk(A_X1, B_Y0, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0);
            5'd9:    u = mk(A_TMP, B_S2, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0);
            5'd10:   u = mk(A_X0, B_Y1, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0);
            5'd11:   u = mk(A_TMP, B_S2, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
            5'd12:   u = mk(A_X2, B_Y1, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0);
            5'd13:   u = mk(A_TMP, B_S0, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0);
            5'd14:   u = mk(A_X1, B_Y2, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0);
            5'd15:   u = mk(A_TMP, B_S0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
            5'd16:   u = mk(A_X0, B_Y2, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0);
            5'd17:   u = mk(A_TMP, B_S1, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0);
            // affine transform of one axis
            5'd18:   u = mk(A_CLO, B_RX, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0);
            5'd19:   u = mk(A_CHI, B_RX, 1'b0, 1'b0, 1'b0, 1'b1, 2'd0);
            5'd20:   u = mk(A_CLO, B_RY, 1'b0, 1'b0, 1'b0, 1'b0, 2'd1);
            5'd21:   u = mk(A_CHI, B_RY, 1'b0, 1'b0, 1'b0, 1'b1, 2'd1);
            5'd22:   u = mk(A_CLO, B_ONE, 1'b0, 1'b0, 1'b0, 1'b0, 2'd2);
            5'd23:   u = mk(A_CHI, B_ONE, 1'b0, 1'b0, 1'b0, 1'b1, 2'd2);
            default: u = mk(A_DX0, B_DY0, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/tcal_dp.sv =====
module tcal_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcal_pkg::TYPE_W-1:0]   event_type,
    input  logic [tcal_pkg::CODE_W-1:0]   event_code,
    input  logic [tcal_pkg::RAW_W-1:0]    event_value,
    input  logic                          cfg_we,
    input  logic [tcal_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcal_pkg::CFG_W-1:0]    cfg_data,
    input  tcal_pkg::cmd_t                cmd,
    output tcal_pkg::st_t                 st,
    output logic [tcal_pkg::PHASE_W-1:0]  phase,
    output logic                          point_captured,
    output logic                          cal_error,
    output logic signed [tcal_pkg::OUT_W-1:0] touch_x,
    output logic signed [tcal_pkg::OUT_W-1:0] touch_y,
    output logic                          pressed
);
    import tcal_pkg::*;

    logic [CFG_W-1:0]          thresh_reg;
    logic [SX_W-1:0]           refx_reg [3];
    logic [SY_W-1:0]           refy_reg [3];
    logic [RAW_W-1:0]          rx_reg, ry_reg;
    logic signed [PRES_W-1:0]  pres_reg;
    logic [RAW_W-1:0]          ptx_reg [3];
    logic [RAW_W-1:0]          pty_reg [3];
    logic signed [COEF_W-1:0]  coef_reg [6];
    logic signed [P_W-1:0]     prod_reg;
    logic signed [MA_W-1:0]    tmp_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [DET_W-1:0]   det_reg;
    logic [DIV_W-1:0]          dn_reg;
    logic [DET_W:0]            dr_reg;
    logic [DET_W-1:0]          dd_reg;
    logic                      dneg_reg;
    logic signed [OUT_W-1:0]   tx_reg, ty_reg;

    // event decode
    logic                      absolute;
    logic [RAW_W-1:0]          x_next, y_next;
    logic signed [PRES_W-1:0]  pres_next;

    assign absolute  = (event_type == ABS_TYPE);
    assign x_next    = (absolute && event_code == CODE_X) ? event_value : rx_reg;
    assign y_next    = (absolute && event_code == CODE_Y) ? event_value : ry_reg;
    assign pres_next = (absolute && event_code == CODE_P) ? $signed({1'b0, event_value})
                                                          : pres_reg;
    assign st.capture = absolute && (pres_next == '0);
    assign st.det_zero = (acc_reg == '0);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            thresh_reg  <= 12'd180;
            refx_reg[0] <= 9'd50;
            refx_reg[1] <= 9'd150;
            refx_reg[2] <= 9'd300;
            refy_reg[0] <= 8'd100;
            refy_reg[1] <= 8'd50;
            refy_reg[2] <= 8'd200;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_THRESH: thresh_reg  <= cfg_data;
                CFG_RX0:    refx_reg[0] <= cfg_data[SX_W-1:0];
                CFG_RX1:    refx_reg[1] <= cfg_data[SX_W-1:0];
                CFG_RX2:    refx_reg[2] <= cfg_data[SX_W-1:0];
                CFG_RY0:    refy_reg[0] <= cfg_data[SY_W-1:0];
                CFG_RY1:    refy_reg[1] <= cfg_data[SY_W-1:0];
                CFG_RY2:    refy_reg[2] <= cfg_data[SY_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            rx_reg   <= '0;
            ry_reg   <= '0;
            pres_reg <= '1;
            for (int i = 0; i < 3; i++)
            begin
                ptx_reg[i] <= '0;
                pty_reg[i] <= '0;
            end
        end
        else if (cmd.take)
        begin
            rx_reg   <= x_next;
            ry_reg   <= y_next;
            pres_reg <= cmd.cap ? '1 : pres_next;
            if (cmd.cap)
            begin
                ptx_reg[cmd.pt_idx] <= x_next;
                pty_reg[cmd.pt_idx] <= y_next;
            end
        end
    end

    // operand selection
    logic [SX_W-1:0]          s0, s1, s2;
    logic signed [MB_W-1:0]   dx0, dx1, dy0, dy1;
    logic signed [SX_W:0]     ds0, ds1;
    logic [2:0]               cidx;
    logic signed [COEF_W-1:0] csel;
    logic signed [MA_W-1:0]   a_op;
    logic signed [MB_W-1:0]   b_op;

    assign s0 = cmd.axis ? {1'b0, refy_reg[0]} : refx_reg[0];
    assign s1 = cmd.axis ? {1'b0, refy_reg[1]} : refx_reg[1];
    assign s2 = cmd.axis ? {1'b0, refy_reg[2]} : refx_reg[2];
    assign dx0 = $signed({1'b0, ptx_reg[0]}) - $signed({1'b0, ptx_reg[2]});
    assign dx1 = $signed({1'b0, ptx_reg[1]}) - $signed({1'b0, ptx_reg[2]});
    assign dy0 = $signed({1'b0, pty_reg[0]}) - $signed({1'b0, pty_reg[2]});
    assign dy1 = $signed({1'b0, pty_reg[1]}) - $signed({1'b0, pty_reg[2]});
    assign ds0 = $signed({1'b0, s0}) - $signed({1'b0, s2});
    assign ds1 = $signed({1'b0, s1}) - $signed({1'b0, s2});
    assign cidx = cmd.axis ? ({1'b0, cmd.uop.cofs} + 3'd3) : {1'b0, cmd.uop.cofs};
    assign csel = coef_reg[cidx];

    always_comb begin
        case (cmd.uop.a_sel)
            A_DX0:   a_op = MA_W'(dx0);
            A_DX1:   a_op = MA_W'(dx1);
            A_DS0:   a_op = MA_W'(ds0);
            A_DS1:   a_op = MA_W'(ds1);
            A_X0:    a_op = $signed({{(MA_W-RAW_W){1'b0}}, ptx_reg[0]});
            A_X1:    a_op = $signed({{(MA_W-RAW_W){1'b0}}, ptx_reg[1]});
            A_X2:    a_op = $signed({{(MA_W-RAW_W){1'b0}}, ptx_reg[2]});
            A_TMP:   a_op = tmp_reg;
            A_CLO:   a_op = $signed({{(MA_W-CLO_W){1'b0}}, csel[CLO_W-1:0]});
            A_CHI:   a_op = MA_W'($signed(csel[COEF_W-1:CLO_W]));
            default: a_op = '0;
        endcase
        case (cmd.uop.b_sel)
            B_DY0:   b_op = dy0;
            B_DY1:   b_op = dy1;
            B_DS1:   b_op = MB_W'(ds1);
            B_DX1:   b_op = dx1;
            B_Y0:    b_op = $signed({1'b0, pty_reg[0]});
            B_Y1:    b_op = $signed({1'b0, pty_reg[1]});
            B_Y2:    b_op = $signed({1'b0, pty_reg[2]});
            B_S0:    b_op = $signed({{(MB_W-SX_W){1'b0}}, s0});
            B_S1:    b_op = $signed({{(MB_W-SX_W){1'b0}}, s1});
            B_S2:    b_op = $signed({{(MB_W-SX_W){1'b0}}, s2});
            B_RX:    b_op = $signed({1'b0, rx_reg});
            B_RY:    b_op = $signed({1'b0, ry_reg});
            B_ONE:   b_op = MB_W'(1);
            default: b_op = '0;
        endcase
    end

    // multiply then accumulate
    logic signed [ACC_W-1:0] prod_ext, addend, acc_base;

    assign prod_ext = {{(ACC_W-P_W){prod_reg[P_W-1]}}, prod_reg};
    assign addend   = cmd.uop.sh20 ? (prod_ext <<< CLO_W) : prod_ext;
    assign acc_base = cmd.uop.clr ? '0 : acc_reg;

    always_ff @(posedge clk) begin
        if (cmd.mul)
            prod_reg <= a_op * b_op;
        if (cmd.acc)
        begin
            if (cmd.uop.tmp)
                tmp_reg <= prod_reg[MA_W-1:0];
            else
                acc_reg <= cmd.uop.neg ? (acc_base - addend) : (acc_base + addend);
        end
        if (cmd.det_load)
            det_reg <= acc_reg[DET_W-1:0];
    end

    // restoring divider, one quotient bit a cycle
    logic signed [ACC_W-1:0] acc_mag;
    logic signed [DET_W-1:0] det_mag;
    logic [DET_W:0]          dr_sh;
    logic                    dge;

    assign acc_mag = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign det_mag = det_reg[DET_W-1] ? -det_reg : det_reg;
    assign dr_sh   = {dr_reg[DET_W-1:0], dn_reg[DIV_W-1]};
    assign dge     = (dr_sh >= {1'b0, dd_reg});

    always_ff @(posedge clk) begin
        if (cmd.div_init)
        begin
            dn_reg   <= {acc_mag[NUM_W-1:0], {FRAC_BITS{1'b0}}};
            dr_reg   <= '0;
            dd_reg   <= det_mag;
            dneg_reg <= acc_reg[ACC_W-1] ^ det_reg[DET_W-1];
        end
        else if (cmd.div_step)
        begin
            dn_reg <= {dn_reg[DIV_W-2:0], dge};
            dr_reg <= dge ? (dr_sh - {1'b0, dd_reg}) : dr_sh;
        end
    end

    // quotient to coefficient with saturation
    logic                    qsat;
    logic signed [COEF_W-1:0] qmag, qval;

    assign qsat = |dn_reg[DIV_W-1:COEF_W-1];
    assign qmag = $signed(dn_reg[COEF_W-1:0]);
    always_comb begin
        if (qsat)
            qval = dneg_reg ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        else
            qval = dneg_reg ? -qmag : qmag;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                coef_reg[i] <= '0;
        end
        else if (cmd.coef_wr)
            coef_reg[cmd.coef_idx] <= qval;
    end

    // scale down, truncate toward zero, saturate to 16 bits
    logic signed [ACC_W-1:0] acc_adj, acc_q;
    logic                    q_fits;
    logic signed [OUT_W-1:0] q16;

    assign acc_adj = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : '0);
    assign acc_q   = acc_adj >>> FRAC_BITS;
    assign q_fits  = (acc_q[ACC_W-1:OUT_W-1] == '0) || (acc_q[ACC_W-1:OUT_W-1] == '1);
    assign q16     = q_fits ? acc_q[OUT_W-1:0]
                            : (acc_q[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                              : {1'b0, {(OUT_W-1){1'b1}}});

    always_ff @(posedge clk) begin
        if (cmd.fin)
        begin
            if (cmd.axis)
                ty_reg <= q16;
            else
                tx_reg <= q16;
        end
    end

    // result register
    logic is_pressed;

    assign is_pressed = (pres_reg >= $signed({1'b0, thresh_reg}));

    always_ff @(posedge clk) begin
        if (cmd.out_load)
        begin
            phase          <= cmd.res_phase;
            point_captured <= cmd.res_cap;
            cal_error      <= cmd.res_err;
            touch_x        <= cmd.res_run ? tx_reg : '0;
            touch_y        <= cmd.res_run ? ty_reg : '0;
            pressed        <= cmd.res_run ? is_pressed : 1'b0;
        end
    end

endmodule

// ===== rtl/tcal_ctrl.sv =====
module tcal_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  tcal_pkg::st_t st,
    output tcal_pkg::cmd_t cmd
);
    import tcal_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_CHK, S_DIVI, S_DIV, S_WR, S_FIN, S_EMIT
    } state_t;

    typedef enum logic [1:0] {PG_DET, PG_NUM, PG_RUN} prog_t;

    state_t             state_reg, state_next;
    prog_t              prog_reg, prog_next;
    logic [UOP_W-1:0]   idx_reg, idx_next, last_reg, last_next;
    logic               axis_reg, axis_next;
    logic [1:0]         k_reg, k_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               cap_reg, cap_next, err_reg, err_next, run_reg, run_next;
    logic               mvalid_reg, mvalid_next;
    logic               accept;

    function automatic logic [UOP_W-1:0] num_first(input logic [1:0] k);
        case (k)
            2'd0:    return UOP_NUM0_FIRST;
            2'd1:    return UOP_NUM1_FIRST;
            default: return UOP_NUM2_FIRST;
        endcase
    endfunction

    function automatic logic [UOP_W-1:0] num_last(input logic [1:0] k);
        case (k)
            2'd0:    return UOP_NUM0_LAST;
            2'd1:    return UOP_NUM1_LAST;
            default: return UOP_NUM2_LAST;
        endcase
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        prog_next   = prog_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        axis_next   = axis_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        cap_next    = cap_reg;
        err_next    = err_reg;
        run_next    = run_reg;
        mvalid_next = mvalid_reg && !m_tready;

        cmd           = '0;
        cmd.uop       = uop_rom(idx_reg);
        cmd.axis      = axis_reg;
        cmd.pt_idx    = phase_reg;
        cmd.coef_idx  = axis_reg ? ({1'b0, k_reg} + 3'd3) : {1'b0, k_reg};
        cmd.res_phase = phase_reg;
        cmd.res_cap   = cap_reg;
        cmd.res_err   = err_reg;
        cmd.res_run   = run_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.take = 1'b1;
                    cmd.cap  = (phase_reg != PHASE_RUN) && st.capture;
                    cap_next = cmd.cap;
                    err_next = 1'b0;
                    run_next = 1'b0;
                    if (phase_reg == PHASE_RUN)
                    begin
                        prog_next  = PG_RUN;
                        axis_next  = 1'b0;
                        idx_next   = UOP_RUN_FIRST;
                        last_next  = UOP_RUN_LAST;
                        state_next = S_MUL;
                    end
                    else if (cmd.cap && phase_reg == PHASE_P2)
                    begin
                        prog_next  = PG_DET;
                        idx_next   = UOP_DET_FIRST;
                        last_next  = UOP_DET_LAST;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        if (cmd.cap)
                            phase_next = phase_reg + 2'd1;
                        state_next = S_EMIT;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (idx_reg == last_reg)
                begin
                    case (prog_reg)
                        PG_DET:  state_next = S_CHK;
                        PG_NUM:  state_next = S_DIVI;
                        default: state_next = S_FIN;
                    endcase
                end
                else
                begin
                    idx_next   = idx_reg + 5'd1;
                    state_next = S_MUL;
                end
            end
            S_CHK:
            begin
                cmd.det_load = 1'b1;
                if (st.det_zero)
                begin
                    phase_next = '0;
                    cap_next   = 1'b1;
                    err_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    prog_next  = PG_NUM;
                    axis_next  = 1'b0;
                    k_next     = 2'd0;
                    idx_next   = UOP_NUM0_FIRST;
                    last_next  = UOP_NUM0_LAST;
                    state_next = S_MUL;
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                    state_next = S_WR;
            end
            S_WR:
            begin
                cmd.coef_wr = 1'b1;
                if (k_reg == 2'd2 && axis_reg)
                begin
                    phase_next = PHASE_RUN;
                    cap_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    if (k_reg == 2'd2)
                    begin
                        axis_next = 1'b1;
                        k_next    = 2'd0;
                    end
                    else
                        k_next = k_reg + 2'd1;
                    idx_next   = num_first(k_next);
                    last_next  = num_last(k_next);
                    state_next = S_MUL;
                end
            end
            S_FIN:
            begin
                cmd.fin = 1'b1;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    idx_next   = UOP_RUN_FIRST;
                    state_next = S_MUL;
                end
                else
                begin
                    run_next   = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            prog_reg   <= PG_DET;
            idx_reg    <= '0;
            last_reg   <= '0;
            axis_reg   <= 1'b0;
            k_reg      <= '0;
            cnt_reg    <= '0;
            phase_reg  <= '0;
            cap_reg    <= 1'b0;
            err_reg    <= 1'b0;
            run_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            prog_reg   <= prog_next;
            idx_reg    <= idx_next;
            last_reg   <= last_next;
            axis_reg   <= axis_next;
            k_reg      <= k_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
            cap_reg    <= cap_next;
            err_reg    <= err_next;
            run_reg    <= run_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// ===== rtl/touch_three_point_calibrator.sv =====
// three point touchscreen calibrator
// s_* channel takes one touch event per item; m_* channel gives one result per item
// cfg_we/cfg_index/cfg_data write the press threshold and the three screen targets
// (index 0 threshold, 1..3 target x, 4..6 target y); write only while idle
// after reset the block collects three points, each ended by an absolute event
// that leaves the pressure latch at zero; the third point starts the solve
// steps from accept to result in the output register:
//   collecting event: straight to the emit state, which loads the result
//   run phase event: two passes of six multiply-accumulate steps
//   third point: determinant, then six numerators, each with a restoring division
// one item is in flight at a time; s_tready is high only while idle
// a result waits in the output register while m_tready is low, and the next
// item is taken meanwhile; its result is held back until the register frees
// reset zeroes x/y latches, calibration points and coefficients, sets pressure to
// all ones, loads default targets and threshold, starts collection at the first point
module touch_three_point_calibrator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // event_type, event_code, event_value, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // phase, point_captured, cal_error, touch_x, touch_y,
                                   // pressed, pad
    input  logic        cfg_we,
    input  logic [tcal_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcal_pkg::CFG_W-1:0]     cfg_data
);
    import tcal_pkg::*;

    cmd_t                    cmd;
    st_t                     st;
    logic [PHASE_W-1:0]      phase;
    logic                    point_captured, cal_error, pressed;
    logic signed [OUT_W-1:0] touch_x, touch_y;

    // controller: sequencing of capture, solve and transform
    tcal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath: latches, shared multiplier, divider, result register
    tcal_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .event_type     (s_tdata[4:0]),
        .event_code     (s_tdata[10:5]),
        .event_value    (s_tdata[22:11]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .st             (st),
        .phase          (phase),
        .point_captured (point_captured),
        .cal_error      (cal_error),
        .touch_x        (touch_x),
        .touch_y        (touch_y),
        .pressed        (pressed)
    );

    assign m_tdata = {3'b000, pressed, touch_y, touch_x, cal_error, point_captured, phase};

    // an accepted item blocks intake on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("intake open right after accept");

    // a failed solve always reports a captured point
    a_err_has_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && cal_error) |-> point_captured)
        else $error("cal_error without point_captured");

    // a failed solve restarts at the first point
    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && cal_error) |-> (phase == '0))
        else $error("cal_error with nonzero phase");

    // press reports only in run phase
    a_press_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && pressed) |-> (phase == PHASE_RUN))
        else $error("pressed outside run phase");

endmodule
